/* src/npi_pkg.sv */
// Shared types, codes and saturation helpers for the Neville point interpolator.
// No dependencies; used by every module under src.
`timescale 1ns / 1ps

package npi_pkg;

    localparam int DEF_MAX_POINTS = 16;

    localparam logic [1:0] FAULT_NONE = 2'd0;
    localparam logic [1:0] FAULT_EQ   = 2'd1;
    localparam logic [1:0] FAULT_CAP  = 2'd2;

    typedef struct packed {
        logic               start_set;
        logic signed [31:0] query_x;
        logic signed [31:0] sample_x;
        logic signed [31:0] sample_y;
        logic               final_point;
    } sample_t;

    typedef struct packed {
        logic signed [31:0] estimate;
        logic [4:0]         points_used;
        logic               is_final;
        logic [1:0]         fault;
    } result_t;

    // One link of the chain: an abscissa and the tableau entry of the same rank
    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] t;
    } cell_t;

    function automatic logic signed [31:0] sat_diff32(input logic signed [31:0] a,
                                                       input logic signed [31:0] b);
        logic signed [32:0] d;
        begin
            d = {a[31], a} - {b[31], b};
            if (d[32] != d[31])
                sat_diff32 = d[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
            else
                sat_diff32 = d[31:0];
        end
    endfunction

    function automatic logic signed [63:0] sat_diff64(input logic signed [63:0] a,
                                                       input logic signed [63:0] b);
        logic signed [64:0] d;
        logic signed [64:0] lim;
        begin
            lim = $signed({2'b00, {63{1'b1}}});
            d   = {a[63], a} - {b[63], b};
            if (d > lim)
                sat_diff64 = lim[63:0];
            else if (d < -lim)
                sat_diff64 = -lim[63:0];
            else
                sat_diff64 = d[63:0];
        end
    endfunction

endpackage

/* src/npi_cell.sv */
// One cell of the abscissa/tableau chain: holds a pair and takes the pair on its d input on shift.
// Depends on npi_pkg.
`timescale 1ns / 1ps

module npi_cell
    import npi_pkg::*;
(
    input  logic  clk,
    input  logic  shift,
    input  cell_t d,
    output cell_t q
);

    cell_t pair_reg;

    always_ff @(posedge clk)
    begin
        if (shift)
        begin
            pair_reg <= d;
        end
    end

    assign q = pair_reg;

endmodule

/* src/npi_div.sv */
// Radix-2 restoring divider: signed 64-bit by signed 32-bit, truncating, saturated to 32 bits.
// Depends on npi_pkg.
`timescale 1ns / 1ps

module npi_div
    import npi_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic signed [63:0] num,
    input  logic signed [31:0] den,
    output logic               done,
    output logic signed [31:0] quo
);

    localparam int NB = 64;
    localparam int KW = $clog2(NB);

    logic [63:0]   a_reg;
    logic [31:0]   b_reg;
    logic [31:0]   rem_reg;
    logic          neg_reg;
    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [KW-1:0] cnt_reg, cnt_next;
    logic [32:0]   rem_sh;
    logic          qbit;
    logic [32:0]   rem_sub;

    assign rem_sh  = {rem_reg, a_reg[63]};
    assign rem_sub = rem_sh - {1'b0, b_reg};
    assign qbit    = (rem_sh >= {1'b0, b_reg});

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
        end
        else if (busy_reg)
        begin
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == KW'(NB - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            neg_reg <= num[63] ^ den[31];
            a_reg   <= num[63] ? 64'(-num) : 64'(num);
            b_reg   <= den[31] ? 32'(-den) : 32'(den);
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg <= qbit ? rem_sub[31:0] : rem_sh[31:0];
            a_reg   <= {a_reg[62:0], qbit};
        end
    end

    // Clamp the magnitude into the signed 32-bit range
    always_comb
    begin
        if (neg_reg)
        begin
            if ((a_reg[63:32] != 32'd0) || (a_reg[31] && (a_reg[30:0] != 31'd0)))
                quo = 32'sh8000_0000;
            else
                quo = -$signed(a_reg[31:0]);
        end
        else
        begin
            if (a_reg[63:31] != 33'd0)
                quo = 32'sh7FFF_FFFF;
            else
                quo = $signed(a_reg[31:0]);
        end
    end

    assign done = done_reg;

endmodule

/* src/neville_point_interpolator_core.sv */
// Neville interpolation, one sample point per transaction, Q16.16 arithmetic.
// Per point, the entry for each of the n stored points passes ST_DIFF, ST_MUL0, ST_MUL1,
// ST_SUB, the 64-step bit-serial divider and ST_INJ (a matching abscissa goes from ST_MUL0
// to ST_INJ). One point at a time: sample_stall stays high until the result is loaded into
// a free output register, also beyond capacity. Reset (rst_n, async, low) clears the point
// count, held query, fault and handshake state; the chain cells are undefined until written.
`timescale 1ns / 1ps

module neville_point_interpolator_core
    import npi_pkg::*;
#(
    parameter int MAX_POINTS = DEF_MAX_POINTS
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    sample_valid,
    output logic    sample_stall,
    input  sample_t sample_item,
    output logic    result_valid,
    input  logic    result_stall,
    output result_t result_item
);

    localparam int CW = $clog2(MAX_POINTS + 1);
    localparam int SW = $clog2(MAX_POINTS);

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_STEP = 4'd1;
    localparam logic [3:0] ST_DIFF = 4'd2;
    localparam logic [3:0] ST_MUL0 = 4'd3;
    localparam logic [3:0] ST_MUL1 = 4'd4;
    localparam logic [3:0] ST_SUB  = 4'd5;
    localparam logic [3:0] ST_DIV  = 4'd6;
    localparam logic [3:0] ST_INJ  = 4'd7;
    localparam logic [3:0] ST_OUT  = 4'd8;

    logic [3:0]         state_reg, state_next;
    logic [SW-1:0]      s_reg, s_next;
    logic [CW-1:0]      count_reg, count_next;
    logic [1:0]         sticky_reg, sticky_next;
    logic signed [31:0] hq_reg, hq_next;
    logic               rv_reg, rv_next;

    logic signed [31:0] xs_reg, ys_reg, q10_reg, row_reg;
    logic signed [31:0] d0_reg, d1_reg, den_reg;
    logic signed [63:0] p0_reg, p1_reg;
    logic               fin_reg, ovf_reg;
    logic [CW-1:0]      n_reg, pts_reg;
    cell_t              prev_reg;
    result_t            res_reg;

    cell_t              chain_q [MAX_POINTS];
    cell_t              head, inj;
    logic               shift_en;
    logic               accept, last_s, take_out;
    logic [CW-1:0]      eff_cnt;
    logic [1:0]         eff_sticky;
    logic signed [31:0] mul_a, mul_b;
    logic signed [63:0] prod;
    logic               div_start, div_done;
    logic signed [31:0] div_quo;

    assign head     = chain_q[0];
    assign accept   = sample_valid && !sample_stall;
    assign last_s   = (s_reg == SW'(MAX_POINTS - 1));
    assign take_out = !rv_reg || !result_stall;
    assign eff_cnt    = sample_item.start_set ? '0 : count_reg;
    assign eff_sticky = sample_item.start_set ? FAULT_NONE : sticky_reg;

    genvar gi;
    generate
        for (gi = 0; gi < MAX_POINTS; gi++)
        begin : g_cell
            if (gi == MAX_POINTS - 1)
            begin : g_tail
                npi_cell u_cell (.clk(clk), .shift(shift_en), .d(inj), .q(chain_q[gi]));
            end
            else
            begin : g_body
                npi_cell u_cell (.clk(clk), .shift(shift_en), .d(chain_q[gi+1]),
                                 .q(chain_q[gi]));
            end
        end
    endgenerate

    // One multiplier, shared by both products of an entry
    assign mul_a = (state_reg == ST_MUL0) ? d0_reg : d1_reg;
    assign mul_b = (state_reg == ST_MUL0) ? q10_reg : prev_reg.t;
    assign prod  = mul_a * mul_b;

    npi_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (sat_diff64(p0_reg, p1_reg)),
        .den   (den_reg),
        .done  (div_done),
        .quo   (div_quo)
    );

    always_comb
    begin
        state_next  = state_reg;
        s_next      = s_reg;
        count_next  = count_reg;
        sticky_next = sticky_reg;
        hq_next     = hq_reg;
        rv_next     = rv_reg && result_stall;
        shift_en    = 1'b0;
        inj         = head;
        div_start   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (sample_item.start_set)
                        hq_next = sample_item.query_x;
                    sticky_next = eff_sticky;
                    if (eff_cnt >= CW'(MAX_POINTS))
                    begin
                        count_next = eff_cnt;
                        if (eff_sticky == FAULT_NONE)
                            sticky_next = FAULT_CAP;
                        state_next = ST_OUT;
                    end
                    else
                    begin
                        count_next = eff_cnt + 1'b1;
                        s_next     = '0;
                        state_next = ST_STEP;
                    end
                end
            end
            ST_STEP:
            begin
                if (s_reg == '0)
                begin
                    inj.x    = xs_reg;
                    inj.t    = ys_reg;
                    shift_en = 1'b1;
                end
                else if (CW'(s_reg) <= n_reg)
                begin
                    state_next = ST_DIFF;
                end
                else
                begin
                    shift_en = 1'b1;
                end
                if (shift_en)
                begin
                    if (last_s)
                        state_next = ST_OUT;
                    else
                        s_next = s_reg + 1'b1;
                end
            end
            ST_DIFF:
            begin
                state_next = ST_MUL0;
            end
            ST_MUL0:
            begin
                if (den_reg == 32'sd0)
                begin
                    if (sticky_reg == FAULT_NONE)
                        sticky_next = FAULT_EQ;
                    state_next = ST_INJ;
                end
                else
                begin
                    state_next = ST_MUL1;
                end
            end
            ST_MUL1:
            begin
                state_next = ST_SUB;
            end
            ST_SUB:
            begin
                div_start  = 1'b1;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (div_done)
                    state_next = ST_INJ;
            end
            ST_INJ:
            begin
                inj.x    = prev_reg.x;
                inj.t    = row_reg;
                shift_en = 1'b1;
                if (last_s)
                    state_next = ST_OUT;
                else
                begin
                    s_next     = s_reg + 1'b1;
                    state_next = ST_STEP;
                end
            end
            ST_OUT:
            begin
                if (take_out)
                begin
                    rv_next    = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            s_reg      <= '0;
            count_reg  <= '0;
            sticky_reg <= FAULT_NONE;
            hq_reg     <= '0;
            rv_reg     <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            s_reg      <= s_next;
            count_reg  <= count_next;
            sticky_reg <= sticky_next;
            hq_reg     <= hq_next;
            rv_reg     <= rv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            xs_reg  <= sample_item.sample_x;
            ys_reg  <= sample_item.sample_y;
            fin_reg <= sample_item.final_point;
            n_reg   <= eff_cnt;
            ovf_reg <= (eff_cnt >= CW'(MAX_POINTS));
            pts_reg <= (eff_cnt >= CW'(MAX_POINTS)) ? eff_cnt : eff_cnt + 1'b1;
        end
        if (shift_en)
        begin
            prev_reg <= head;
        end
        if (state_reg == ST_STEP && s_reg == '0)
        begin
            q10_reg <= ys_reg;
        end
        if (state_reg == ST_INJ)
        begin
            q10_reg <= row_reg;
        end
        if (state_reg == ST_DIFF)
        begin
            d0_reg  <= sat_diff32(hq_reg, prev_reg.x);
            d1_reg  <= sat_diff32(hq_reg, xs_reg);
            den_reg <= sat_diff32(xs_reg, prev_reg.x);
        end
        if (state_reg == ST_MUL0)
        begin
            // Equal abscissas: carry the left entry across
            if (den_reg == 32'sd0)
                row_reg <= q10_reg;
            else
                p0_reg <= prod;
        end
        if (state_reg == ST_MUL1)
        begin
            p1_reg <= prod;
        end
        if (state_reg == ST_DIV && div_done)
        begin
            row_reg <= div_quo;
        end
        if (state_reg == ST_OUT && take_out)
        begin
            res_reg.estimate    <= ovf_reg ? chain_q[MAX_POINTS-1].t : q10_reg;
            res_reg.points_used <= 5'(pts_reg);
            res_reg.is_final    <= fin_reg;
            res_reg.fault       <= sticky_reg;
        end
    end

    assign sample_stall = (state_reg != ST_IDLE);
    assign result_valid = rv_reg;
    assign result_item  = res_reg;

endmodule
